// File: rtl/core/spq_pkg.sv
package spq_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 16;
    localparam int ID_W                = 6;
    localparam int PRIO_W              = 8;

    localparam logic            KIND_PUSH = 1'b0;
    localparam logic            KIND_POP  = 1'b1;
    localparam logic [ID_W-1:0] IDLE_TASK = '0;

    typedef struct packed {
        logic              kind;
        logic [ID_W-1:0]   task_id;
        logic [PRIO_W-1:0] task_priority;
    } req_t;

    typedef struct packed {
        logic [ID_W-1:0] chosen_task;
        logic            was_empty;
    } rsp_t;

    // One stored entry: priority above id.
    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [ID_W-1:0]   id;
    } entry_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } store_ctl_t;

endpackage

// File: rtl/core/spq_store.sv
module spq_store
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT,
    localparam int PTR_W      = $clog2(QUEUE_DEPTH)
)
(
    input  logic             clk,
    input  store_ctl_t       ctl,
    input  logic [PTR_W-1:0] rd_addr,
    input  logic [PTR_W-1:0] wr_addr,
    input  entry_t           wr_data,
    output entry_t           rd_data
);

    entry_t mem [QUEUE_DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/stable_priority_ready_queue.sv
// Ready queue for a task scheduler: entries (task id, priority) kept sorted from highest
// to lowest priority in a ring held in one single-port-read memory, with equal priorities
// leaving in push order. A pop reads the front entry from memory, then loads the result
// register once it is free; a pop of an empty queue returns the idle task 0 with was_empty
// set. A push into an empty queue writes the entry directly; otherwise every entry of lower
// priority is moved one slot back, one memory read and write per cycle, and the new entry
// is written into the freed slot. A push into a full queue is dropped.
// One request is in work at a time; a finished pop result waits in the output register.
module stable_priority_ready_queue
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_SCAN,
        ST_PLACE
    } state_t;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == LAST_PTR) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        return (p == '0) ? LAST_PTR : p - PTR_W'(1);
    endfunction

    state_t           state_reg;
    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] tail_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [CNT_W-1:0] remain_reg;
    entry_t           new_entry_reg;
    logic             rsp_valid_reg;
    rsp_t             rsp_reg;

    store_ctl_t       st_ctl;
    logic [PTR_W-1:0] st_rd_addr;
    logic [PTR_W-1:0] st_wr_addr;
    entry_t           st_wr_data;
    entry_t           st_rd_data;

    entry_t req_entry;
    logic   req_take;
    logic   shift_back;
    logic   rsp_free;

    assign req_entry  = '{prio: req.task_priority, id: req.task_id};
    assign req_stall  = (state_reg != ST_IDLE);
    assign req_take   = req_valid && !req_stall;
    assign shift_back = (st_rd_data.prio < new_entry_reg.prio);
    assign rsp_free   = !rsp_valid_reg || !rsp_stall;

    // Reads always run ahead of the write pointer, so the same slot is never
    // read and written in one cycle.
    always_comb
    begin
        st_ctl     = '0;
        st_rd_addr = head_reg;
        st_wr_addr = wr_ptr_reg;
        st_wr_data = new_entry_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_take)
                begin
                    if (req.kind == KIND_POP)
                    begin
                        st_ctl.rd_en = 1'b1;
                    end
                    else if (count_reg == '0)
                    begin
                        st_ctl.wr_en = 1'b1;
                        st_wr_addr   = tail_reg;
                        st_wr_data   = req_entry;
                    end
                    else if (count_reg != FULL_CNT)
                    begin
                        st_ctl.rd_en = 1'b1;
                        st_rd_addr   = ptr_dec(tail_reg);
                    end
                end
            end
            ST_SCAN:
            begin
                st_ctl.wr_en = 1'b1;
                if (shift_back)
                begin
                    st_wr_data = st_rd_data;
                    if (remain_reg != ONE_CNT)
                    begin
                        st_ctl.rd_en = 1'b1;
                        st_rd_addr   = ptr_dec(rd_ptr_reg);
                    end
                end
            end
            ST_PLACE:
            begin
                st_ctl.wr_en = 1'b1;
            end
            ST_POP:
            begin
                st_ctl = '0;
            end
            default:
            begin
                st_ctl = '0;
            end
        endcase
    end

    spq_store #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_store (
        .clk     (clk),
        .ctl     (st_ctl),
        .rd_addr (st_rd_addr),
        .wr_addr (st_wr_addr),
        .wr_data (st_wr_data),
        .rd_data (st_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            remain_reg    <= '0;
            new_entry_reg <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            // The pop state reloads the result register itself.
            if (rsp_valid_reg && !rsp_stall && state_reg != ST_POP)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req_take)
                    begin
                        new_entry_reg <= req_entry;
                        if (req.kind == KIND_POP)
                        begin
                            state_reg <= ST_POP;
                        end
                        else if (count_reg == '0)
                        begin
                            tail_reg  <= ptr_inc(tail_reg);
                            count_reg <= count_reg + ONE_CNT;
                        end
                        else if (count_reg != FULL_CNT)
                        begin
                            wr_ptr_reg <= tail_reg;
                            rd_ptr_reg <= ptr_dec(tail_reg);
                            remain_reg <= count_reg;
                            state_reg  <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (shift_back)
                    begin
                        // Move the lower entry back one slot and look further ahead.
                        wr_ptr_reg <= rd_ptr_reg;
                        rd_ptr_reg <= ptr_dec(rd_ptr_reg);
                        remain_reg <= remain_reg - ONE_CNT;
                        if (remain_reg == ONE_CNT)
                        begin
                            state_reg <= ST_PLACE;
                        end
                    end
                    else
                    begin
                        tail_reg  <= ptr_inc(tail_reg);
                        count_reg <= count_reg + ONE_CNT;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_PLACE:
                begin
                    tail_reg  <= ptr_inc(tail_reg);
                    count_reg <= count_reg + ONE_CNT;
                    state_reg <= ST_IDLE;
                end
                ST_POP:
                begin
                    // Hold the front entry until the result register frees up.
                    if (rsp_free)
                    begin
                        rsp_valid_reg <= 1'b1;
                        if (count_reg == '0)
                        begin
                            rsp_reg <= '{chosen_task: IDLE_TASK, was_empty: 1'b1};
                        end
                        else
                        begin
                            rsp_reg   <= '{chosen_task: st_rd_data.id, was_empty: 1'b0};
                            head_reg  <= ptr_inc(head_reg);
                            count_reg <= count_reg - ONE_CNT;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("entry count above queue depth");

    a_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.was_empty |-> rsp.chosen_task == IDLE_TASK)
        else $error("empty pop did not return the idle task");

    a_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_take && req.kind == KIND_POP |=> req_stall)
        else $error("pop request not held off while the front entry is read");

    a_ring_span: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE && count_reg == '0 |-> head_reg == tail_reg)
        else $error("empty ring with head and tail apart");

endmodule
